// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FNM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fnm assertion failed");
`define FNM_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fnm assertion failed");
`else
`define FNM_ASSERT(lbl, clk, rst_n, prop)
`define FNM_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

// ===== hdl/fnm_pkg.sv =====
// ----------------------------------------------------------------------------
// fnm_pkg
// types, codes and the sine table of the fsk nco modulator
// ----------------------------------------------------------------------------
package fnm_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] REG_SPB    = 2'd0;
    localparam logic [1:0] REG_LEN    = 2'd1;
    localparam logic [1:0] REG_SHIFT  = 2'd2;
    localparam logic [1:0] REG_NOTICE = 2'd3;

    localparam int CFG_W = 21;

    localparam logic [31:0] PHASE_SCALE  = 32'd1883;
    localparam logic [11:0] BIT_OVERRUN  = 12'd4;
    localparam logic [7:0]  QUARTER_TURN = 8'd64;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_address;
        logic [7:0] byte_value;
    } cmd_t;

    typedef struct packed {
        logic signed [7:0] i_sample;
        logic signed [7:0] q_sample;
        logic [15:0]       progress_total;
        logic              progress_event;
        logic              done_res;
    } sample_t;

    function automatic logic [6:0] quarter_sine(input logic [6:0] idx);
        logic [6:0] v;
        case (idx)
            7'd0:  v = 7'd0;   7'd1:  v = 7'd3;   7'd2:  v = 7'd6;   7'd3:  v = 7'd9;
            7'd4:  v = 7'd12;  7'd5:  v = 7'd16;  7'd6:  v = 7'd19;  7'd7:  v = 7'd22;
            7'd8:  v = 7'd25;  7'd9:  v = 7'd28;  7'd10: v = 7'd31;  7'd11: v = 7'd34;
            7'd12: v = 7'd37;  7'd13: v = 7'd40;  7'd14: v = 7'd43;  7'd15: v = 7'd46;
            7'd16: v = 7'd49;  7'd17: v = 7'd51;  7'd18: v = 7'd54;  7'd19: v = 7'd57;
            7'd20: v = 7'd60;  7'd21: v = 7'd63;  7'd22: v = 7'd65;  7'd23: v = 7'd68;
            7'd24: v = 7'd71;  7'd25: v = 7'd73;  7'd26: v = 7'd76;  7'd27: v = 7'd78;
            7'd28: v = 7'd81;  7'd29: v = 7'd83;  7'd30: v = 7'd85;  7'd31: v = 7'd88;
            7'd32: v = 7'd90;  7'd33: v = 7'd92;  7'd34: v = 7'd94;  7'd35: v = 7'd96;
            7'd36: v = 7'd98;  7'd37: v = 7'd100; 7'd38: v = 7'd102; 7'd39: v = 7'd104;
            7'd40: v = 7'd106; 7'd41: v = 7'd107; 7'd42: v = 7'd109; 7'd43: v = 7'd111;
            7'd44: v = 7'd112; 7'd45: v = 7'd113; 7'd46: v = 7'd115; 7'd47: v = 7'd116;
            7'd48: v = 7'd117; 7'd49: v = 7'd118; 7'd50: v = 7'd120; 7'd51: v = 7'd121;
            7'd52: v = 7'd122; 7'd53: v = 7'd122; 7'd54: v = 7'd123; 7'd55: v = 7'd124;
            7'd56: v = 7'd125; 7'd57: v = 7'd125; 7'd58: v = 7'd126; 7'd59: v = 7'd126;
            7'd60: v = 7'd126; 7'd61: v = 7'd127; 7'd62: v = 7'd127; 7'd63: v = 7'd127;
            7'd64: v = 7'd127;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // full turn from the quarter table, top two bits pick the quadrant
    function automatic logic signed [7:0] sine_of(input logic [7:0] idx);
        logic [6:0] q;
        logic [6:0] mag;
        q   = {1'b0, idx[5:0]};
        mag = idx[6] ? quarter_sine(7'd64 - q) : quarter_sine(q);
        return idx[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ===== hdl/fnm_ram.sv =====
// ----------------------------------------------------------------------------
// fnm_ram
// simple dual port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module fnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/fsk_nco_modulator.sv =====
// ----------------------------------------------------------------------------
// fsk_nco_modulator
// binary fsk baseband modulator: message store, bit sequencer, nco, sine table
// ----------------------------------------------------------------------------
// usage: words on the cmd channel write a message byte, start a transmission
// or request one sample tick. each tick word gives one word on the sample
// channel with the i/q pair, the progress count and the event/done flags;
// write and start words give nothing back.
// path: a word is taken into an input register, worked on from there once
// it can go, and its sample word is registered in the output register.
// throughput: one word per clock while no start fetch, sweep or held sample
// word stops it. after a start the next word waits while the first two
// message bytes are read from the store ram (one registered read port).
// reset: control registers go to zero, the data registers are not reset, and
// the store is swept to zero, one byte a cycle, while words are held in the input register.
// stall: a sample word waits in its output register while sample_ready is
// low; write and start words still pass, and the cmd channel takes one more
// tick word, which waits in the input register with cmd_ready low.
// config: cfg_we writes a register; writes are taken at any time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_nco_modulator #(
    parameter int MESSAGE_BYTES = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [fnm_pkg::CFG_W-1:0] cfg_data,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  fnm_pkg::cmd_t            cmd,
    output logic                     sample_valid,
    input  logic                     sample_ready,
    output fnm_pkg::sample_t         sample
);

    import fnm_pkg::*;

    localparam int AW = $clog2(MESSAGE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MESSAGE_BYTES - 1);

    typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_FETCH0, ST_FETCH1} state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [15:0] spb_reg, spb_next;
    logic [10:0] len_reg, len_next;
    logic [31:0] step_reg, step_next;
    logic [15:0] notice_reg, notice_next;

    logic cmd_full_reg, cmd_full_next;
    cmd_t cmd_reg, cmd_next;

    logic [31:0] phase_reg, phase_next;
    logic [15:0] tick_cnt_reg, tick_cnt_next;
    logic [11:0] bit_index_reg, bit_index_next;
    logic        cur_bit_reg, cur_bit_next;
    logic [15:0] group_cnt_reg, group_cnt_next;
    logic [15:0] pulse_total_reg, pulse_total_next;
    logic        active_reg, active_next;

    // bytes at the current and the following byte address, kept in step with writes
    logic [7:0]    cur_byte_reg, cur_byte_next;
    logic [7:0]    next_byte_reg, next_byte_next;
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic [AW-1:0] next_addr_reg, next_addr_next;
    logic          pending_reg, pending_next;

    logic    rsp_valid_reg, rsp_valid_next;
    sample_t rsp_reg, rsp_next;

    logic          proc;
    logic          crossing;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] addr_inc;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] wrap_rom [256];

    // byte address modulo the store depth
    for (genvar g = 0; g < 256; g++)
    begin : g_wrap
        assign wrap_rom[g] = AW'(g % MESSAGE_BYTES);
    end

    assign wr_addr  = wrap_rom[cmd_reg.byte_address];
    assign addr_inc = (next_addr_reg == LAST_ADDR) ? '0 : next_addr_reg + AW'(1);

    assign proc = cmd_full_reg && (state_reg == ST_RUN)
                  && ((cmd_reg.op != OP_TICK) || !rsp_valid_reg || sample_ready);
    assign cmd_ready = !cmd_full_reg || proc;

    assign ram_raddr = (state_reg == ST_FETCH0) ? cur_addr_reg : next_addr_next;

    fnm_ram #(
        .WIDTH (8),
        .DEPTH (MESSAGE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        spb_next         = spb_reg;
        len_next         = len_reg;
        step_next        = step_reg;
        notice_next      = notice_reg;
        cmd_full_next    = cmd_full_reg;
        cmd_next         = cmd_reg;
        phase_next       = phase_reg;
        tick_cnt_next    = tick_cnt_reg;
        bit_index_next   = bit_index_reg;
        cur_bit_next     = cur_bit_reg;
        group_cnt_next   = group_cnt_reg;
        pulse_total_next = pulse_total_reg;
        active_next      = active_reg;
        cur_byte_next    = cur_byte_reg;
        next_byte_next   = next_byte_reg;
        cur_addr_next    = cur_addr_reg;
        next_addr_next   = next_addr_reg;
        pending_next     = 1'b0;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        crossing         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = clr_cnt_reg;
        ram_wdata        = 8'd0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SPB:    spb_next    = cfg_data[15:0];
                REG_LEN:    len_next    = cfg_data[10:0];
                REG_SHIFT:  step_next   = 32'(cfg_data) * PHASE_SCALE;
                REG_NOTICE: notice_next = cfg_data[15:0];
                default:    spb_next    = spb_reg;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_FETCH0:
            begin
                state_next = ST_FETCH1;
            end
            ST_FETCH1:
            begin
                cur_byte_next = ram_rdata;
                pending_next  = 1'b1;
                state_next    = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // read data of the following byte lands in the cycle after its address
        if (pending_reg)
        begin
            next_byte_next = ram_rdata;
        end

        if (cmd_ready)
        begin
            cmd_full_next = cmd_valid;
            if (cmd_valid)
            begin
                cmd_next = cmd;
            end
        end

        if (sample_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (proc)
        begin
            case (cmd_reg.op)
                OP_WRITE:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr;
                    ram_wdata = cmd_reg.byte_value;
                    if (wr_addr == cur_addr_reg)
                    begin
                        cur_byte_next = cmd_reg.byte_value;
                    end
                    if (wr_addr == next_addr_reg)
                    begin
                        next_byte_next = cmd_reg.byte_value;
                    end
                end
                OP_START:
                begin
                    tick_cnt_next    = spb_reg;
                    group_cnt_next   = 16'd0;
                    bit_index_next   = 12'd0;
                    cur_bit_next     = 1'b0;
                    pulse_total_next = 16'd0;
                    active_next      = 1'b1;
                    cur_addr_next    = '0;
                    next_addr_next   = AW'(1);
                    state_next       = ST_FETCH0;
                end
                OP_TICK:
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.progress_event = 1'b0;
                    rsp_next.done_res       = 1'b0;
                    rsp_next.i_sample       = 8'sd0;
                    rsp_next.q_sample       = 8'sd0;
                    if (active_reg)
                    begin
                        if (tick_cnt_reg >= spb_reg)
                        begin
                            if (bit_index_reg > (12'(len_reg) + BIT_OVERRUN))
                            begin
                                cur_bit_next      = 1'b0;
                                rsp_next.done_res = 1'b1;
                                active_next       = 1'b0;
                            end
                            else
                            begin
                                cur_bit_next   = cur_byte_reg[3'd7 - bit_index_reg[2:0]];
                                bit_index_next = bit_index_reg + 12'd1;
                                if (bit_index_reg[2:0] == 3'd7)
                                begin
                                    crossing       = 1'b1;
                                    cur_byte_next  = next_byte_reg;
                                    cur_addr_next  = next_addr_reg;
                                    next_addr_next = addr_inc;
                                    pending_next   = 1'b1;
                                end
                                if (group_cnt_reg >= notice_reg)
                                begin
                                    group_cnt_next          = 16'd0;
                                    pulse_total_next        = pulse_total_reg + 16'd1;
                                    rsp_next.progress_event = 1'b1;
                                end
                                else
                                begin
                                    group_cnt_next = group_cnt_reg + 16'd1;
                                end
                            end
                            tick_cnt_next = 16'd0;
                        end
                        else
                        begin
                            tick_cnt_next = tick_cnt_reg + 16'd1;
                        end

                        if (active_next)
                        begin
                            phase_next = cur_bit_next ? phase_reg - step_reg
                                                      : phase_reg + step_reg;
                            rsp_next.q_sample = sine_of(phase_next[31:24]);
                            rsp_next.i_sample = sine_of(phase_next[31:24] + QUARTER_TURN);
                        end
                    end
                    rsp_next.progress_total = pulse_total_next;
                end
                default:
                begin
                    cmd_full_next = cmd_full_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            spb_reg         <= 16'd0;
            len_reg         <= 11'd0;
            step_reg        <= 32'd0;
            notice_reg      <= 16'd0;
            cmd_full_reg    <= 1'b0;
            phase_reg       <= 32'd0;
            tick_cnt_reg    <= 16'd0;
            bit_index_reg   <= 12'd0;
            cur_bit_reg     <= 1'b0;
            group_cnt_reg   <= 16'd0;
            pulse_total_reg <= 16'd0;
            active_reg      <= 1'b0;
            cur_addr_reg    <= '0;
            next_addr_reg   <= '0;
            pending_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            spb_reg         <= spb_next;
            len_reg         <= len_next;
            step_reg        <= step_next;
            notice_reg      <= notice_next;
            cmd_full_reg    <= cmd_full_next;
            phase_reg       <= phase_next;
            tick_cnt_reg    <= tick_cnt_next;
            bit_index_reg   <= bit_index_next;
            cur_bit_reg     <= cur_bit_next;
            group_cnt_reg   <= group_cnt_next;
            pulse_total_reg <= pulse_total_next;
            active_reg      <= active_next;
            cur_addr_reg    <= cur_addr_next;
            next_addr_reg   <= next_addr_next;
            pending_reg     <= pending_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cur_byte_reg  <= cur_byte_next;
        next_byte_reg <= next_byte_next;
        rsp_reg       <= rsp_next;
    end

    assign sample_valid = rsp_valid_reg;
    assign sample       = rsp_reg;

    // a start holds the pipe for the two store reads
    `FNM_ASSERT(a_start_fetch, clk, rst_n, (proc && (cmd_reg.op == OP_START)) |=> !proc ##1 !proc)
    // a read is only outstanding after the start fetch or a byte crossing
    `FNM_ASSERT(a_pending_src, clk, rst_n, pending_reg |-> $past((state_reg == ST_FETCH1) || crossing))
    // no sample word while the store is being swept
    `FNM_ASSERT_NORST(a_clear_quiet, clk, (state_reg == ST_CLEAR) |-> !rsp_valid_reg)
    // a transmission only ends with a done word
    `FNM_ASSERT(a_end_done, clk, rst_n, $fell(active_reg) |-> (rsp_valid_reg && rsp_reg.done_res))

endmodule

// ===== tb/fsk_nco_modulator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsk_nco_modulator_tb
// self-checking bench for the binary fsk nco modulator
// ----------------------------------------------------------------------------
// drives write, start, tick and nop words on the cmd channel. A local bit-accurate
// model of the bit sequencer, phase accumulator and sine lookup predicts one
// sample word per tick, and every sample word is checked in order against it.
// Directed tests cover idle output, a short frame, restart and slow bits.
// Random phases follow, each with its own register settings and idle mix,
// and a long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module fsk_nco_modulator_tb;

    import fnm_pkg::*;

    localparam logic [1:0] OP_NOP      = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 4;
    localparam int         FRAME_BYTES = 6;

    // sine magnitude for 0..64 steps of a quarter turn, index 0 leftmost
    localparam logic [0:64][6:0] SINE_MAG = {
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
        7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               cmd_valid;
    logic               cmd_ready;
    cmd_t               cmd;
    logic               sample_valid;
    logic               sample_ready;
    sample_t            sample;

    // register copies
    logic [15:0]        spb_reg;
    logic [10:0]        len_reg;
    logic [20:0]        shift_reg;
    logic [15:0]        notice_reg;

    // modulator state
    logic [31:0]        phase;
    logic [15:0]        ticks;
    logic [11:0]        bit_pos;
    logic               cur_bit;
    logic [15:0]        group_cnt;
    logic [15:0]        pulse_cnt;
    logic               running;
    logic [7:0]         msg_store [256];

    sample_t            pending_samples [$];

    int                 send_idle_pct;
    int                 stall_pct;
    int                 hold_left;
    int                 mismatch_count;
    int                 cycle_count;

    fsk_nco_modulator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample)
    );

    always #6 clk = ~clk;

    function automatic logic signed [7:0] nco_sine(input logic [7:0] angle);
        int off;
        int mag;
        off = int'(angle[5:0]);
        if (angle[6])
            mag = int'(SINE_MAG[64 - off]);
        else
            mag = int'(SINE_MAG[off]);
        if (angle[7])
            mag = -mag;
        return mag[7:0];
    endfunction

    // advance the model by one accepted cmd word
    task automatic fsk_step(input cmd_t w);
        sample_t     s;
        logic [31:0] step;
        s = '0;
        case (w.op)
            OP_WRITE: msg_store[w.byte_address] = w.byte_value;
            OP_START:
            begin
                ticks     = spb_reg;
                group_cnt = '0;
                bit_pos   = '0;
                cur_bit   = 1'b0;
                pulse_cnt = '0;
                running   = 1'b1;
            end
            OP_TICK:
            begin
                if (running)
                begin
                    if (ticks >= spb_reg)
                    begin
                        if (int'(bit_pos) > int'(len_reg) + int'(BIT_OVERRUN))
                        begin
                            cur_bit    = 1'b0;
                            s.done_res = 1'b1;
                            running    = 1'b0;
                        end
                        else
                        begin
                            cur_bit = msg_store[bit_pos[10:3]][3'd7 - bit_pos[2:0]];
                            bit_pos = bit_pos + 12'd1;
                            if (group_cnt >= notice_reg)
                            begin
                                group_cnt        = '0;
                                pulse_cnt        = pulse_cnt + 16'd1;
                                s.progress_event = 1'b1;
                            end
                            else
                                group_cnt = group_cnt + 16'd1;
                        end
                        ticks = '0;
                    end
                    else
                        ticks = ticks + 16'd1;

                    if (running)
                    begin
                        step = {11'd0, shift_reg} * PHASE_SCALE;
                        phase = cur_bit ? phase - step : phase + step;
                        s.q_sample = nco_sine(phase[31:24]);
                        s.i_sample = nco_sine(phase[31:24] + QUARTER_TURN);
                    end
                end
                s.progress_total = pulse_cnt;
                pending_samples.push_back(s);
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [1:0] op, input logic [7:0] addr,
                             input logic [7:0] val);
        cmd_t w;
        w.op           = op;
        w.byte_address = addr;
        w.byte_value   = val;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (!cmd_ready);
        fsk_step(w);
    endtask

    // drop valid and let every outstanding sample word come back
    task automatic wait_idle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_SPB:    spb_reg    = val[15:0];
            REG_LEN:    len_reg    = val[10:0];
            REG_SHIFT:  shift_reg  = val[20:0];
            REG_NOTICE: notice_reg = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int spb, input int len, input int shift,
                              input int notice);
        wait_idle();
        write_reg(REG_SPB, CFG_W'(spb));
        write_reg(REG_LEN, CFG_W'(len));
        write_reg(REG_SHIFT, CFG_W'(shift));
        write_reg(REG_NOTICE, CFG_W'(notice));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // frames of message writes, a start and ticks to finish, cut at the word budget, with noise
    task automatic run_frames(input int budget);
        int sent;
        int nbytes;
        int nticks;
        sent = 0;
        while (sent < budget)
        begin
            nbytes = int'(len_reg) / 8 + 1;
            if (nbytes > FRAME_BYTES)
                nbytes = FRAME_BYTES;
            for (int k = 0; k < nbytes; k++)
            begin
                send_word(OP_WRITE, 8'(k), 8'($urandom_range(255)));
                sent++;
            end
            send_word(OP_START, 8'($urandom_range(255)), 8'($urandom_range(255)));
            sent++;
            nticks = (int'(len_reg) + 6) * (int'(spb_reg) + 1) + $urandom_range(2);
            if (nticks > budget - sent + 2)
                nticks = budget - sent + 2;
            for (int t = 0; t < nticks; t++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    case ($urandom_range(3))
                        0: send_word(OP_NOP, 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                        1:
                        begin
                            send_word(OP_WRITE, 8'($urandom_range(255)),
                                      8'($urandom_range(255)));
                            sent++;
                        end
                        2:
                        begin
                            send_word(OP_START, 8'($urandom_range(255)),
                                      8'($urandom_range(255)));
                            sent++;
                        end
                        default:
                        begin
                            // overwrite one of the bytes of the frame
                            send_word(OP_WRITE, 8'($urandom_range(nbytes - 1)),
                                      8'($urandom_range(255)));
                            sent++;
                        end
                    endcase
                end
                send_word(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    task automatic test_idle_output();
        send_word(OP_TICK, 8'h00, 8'h00);
        send_word(OP_NOP, 8'hFF, 8'hFF);
        send_word(OP_WRITE, 8'hFF, 8'hFF);
        send_word(OP_WRITE, 8'h00, 8'h00);
        send_word(OP_TICK, 8'hFF, 8'hFF);
    endtask

    // one bit per tick, pulse on every bit, runs through to done
    task automatic test_short_frame();
        set_config(0, 0, 1140000, 0);
        send_word(OP_WRITE, 8'h00, 8'hA5);
        send_word(OP_START, 8'h00, 8'h00);
        repeat (7) send_word(OP_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_restart();
        set_config(1, 3, 555555, 1);
        send_word(OP_START, 8'h00, 8'h00);
        repeat (3) send_word(OP_TICK, 8'h00, 8'h00);
        send_word(OP_START, 8'h00, 8'h00);
        repeat (3) send_word(OP_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_slow_bits();
        set_config(65535, 0, 0, 0);
        send_word(OP_START, 8'h00, 8'h00);
        repeat (3) send_word(OP_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall,
                                     input bit extremes, input int budget);
        if (extremes)
            set_config(0, 2043, 1140000, 65535);
        else
            set_config($urandom_range(3), $urandom_range(24),
                       $urandom_range(1140000), $urandom_range(4));
        @(posedge clk);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        run_frames(budget);
    endtask

    // receiver holds off while words keep coming, so the input side stalls
    task automatic test_backpressure();
        set_config(0, $urandom_range(16), $urandom_range(1140000), $urandom_range(3));
        @(posedge clk);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 400;
        run_frames(120);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            sample_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            sample_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_samples
        sample_t want;
        if (rst_n && sample_valid && sample_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected sample word: i=%0d q=%0d total=%0d ev=%0b done=%0b",
                             sample.i_sample, sample.q_sample, sample.progress_total,
                             sample.progress_event, sample.done_res);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample.i_sample !== want.i_sample ||
                    sample.q_sample !== want.q_sample ||
                    sample.progress_total !== want.progress_total ||
                    sample.progress_event !== want.progress_event ||
                    sample.done_res !== want.done_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                                 want.i_sample, want.q_sample, want.progress_total,
                                 want.progress_event, want.done_res,
                                 sample.i_sample, sample.q_sample, sample.progress_total,
                                 sample.progress_event, sample.done_res);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        sample_ready   = 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_left      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        spb_reg        = '0;
        len_reg        = '0;
        shift_reg      = '0;
        notice_reg     = '0;
        phase          = '0;
        ticks          = '0;
        bit_pos        = '0;
        cur_bit        = 1'b0;
        group_cnt      = '0;
        pulse_cnt      = '0;
        running        = 1'b0;
        for (int k = 0; k < 256; k++)
            msg_store[k] = 8'h00;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_output();
        test_short_frame();
        test_restart();
        test_slow_bits();
        test_random_phase(0, 0, 1'b1, 200);
        test_random_phase(0, 0, 1'b0, 200);
        test_random_phase(64, 0, 1'b0, 200);
        test_random_phase(0, 64, 1'b0, 200);
        test_random_phase(25, 25, 1'b0, 200);
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
